// File: sv/sdfs_pkg.sv
package sdfs_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W  = 8;
  localparam int POS_W     = 8;
  localparam int CNT_W     = 9;
  localparam int CFG_IDX_W = 2;

  // Defaults for the top-level parameters
  localparam int TAP_COUNT_DEF  = 21;
  localparam int MAX_COLUMN_DEF = 256;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_OFFSET   = 2'd1;
  localparam logic [SAMPLE_W-1:0]  THR_RESET          = 8'd50;
  localparam logic [SAMPLE_W-1:0]  OFF_RESET          = 8'd8;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;

  // Filter arithmetic: Q1.15 weights, products of 9-bit differences
  localparam int WEIGHT_W    = 16;
  localparam int DIFF_W      = 9;
  localparam int PROD_W      = 25;
  localparam int GROUP_SIZE  = 4;
  localparam int GRP_W       = 27;
  localparam int ACC_W       = 29;
  localparam int Q_SHIFT     = 15;
  localparam int QUOT_W      = ACC_W - 1 - Q_SHIFT;
  localparam int SAT_LIMIT   = 1280;   // 256 * 5, first quotient that saturates
  localparam int DIV_IN_W    = 11;
  localparam int RECIP_W     = 27;
  localparam int RECIP       = 52429;  // round(2^18 / 5)
  localparam int RECIP_SHIFT = 18;

  // tanh(k/4) in Q1.15 for k = 0..15
  localparam logic [14:0] TANH_Q15 [16] = '{
    15'd0,     15'd8026,  15'd15143, 15'd20813, 15'd24956, 15'd27797, 15'd29660, 15'd30847,
    15'd31589, 15'd32048, 15'd32329, 15'd32501, 15'd32606, 15'd32670, 15'd32708, 15'd32732
  };

  function automatic logic signed [WEIGHT_W-1:0] tap_weight(input int k);
    logic [3:0] sel;
    sel = k[3:0];
    return $signed({1'b0, TANH_Q15[sel]});
  endfunction

  // One classified sample on its way from front to back
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                push;      // sample enters the window
    logic                first;     // first sample: fill the whole window
    logic                consider;  // window center is a real position
    logic                last;      // column ends after this sample
    logic [POS_W-1:0]    pos;       // center position when considered
    logic [POS_W-1:0]    len_m1;    // column length minus one, on last
  } item_t;

  // Control that travels with each window step down the filter pipeline
  typedef struct packed {
    logic             consider;
    logic             fin;          // last step of the column
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] len_m1;
  } tag_t;

endpackage

// File: sv/surface_depth_from_scan_column.sv
// Surface depth detector: streams the 8-bit samples of one depth column in z order
// (tlast on the final one), filters them with an antisymmetric tanh step kernel of
// TAP_COUNT taps (edges replicated), scales by 1/5 and clamps to 0..255, then keeps the
// running maximum up to the first value above peak_threshold. One result per column:
// depth_index = peak index + depth_offset capped at the column end, or column length
// minus one when no peak reaches the threshold; peak_found tells which. Samples beyond
// MAX_COLUMN are ignored. Within a column the input takes one sample per cycle while the
// queue has room. After the last sample of a column the back end replicates the edge
// sample to flush the window; the four-entry queue takes the first four samples of the
// next column during that flush, after which the input stalls. After the flush the
// result passes the window, product, group-sum, sum and scale registers and the result
// register before it is valid. While a result waits, the whole back end holds.
module surface_depth_from_scan_column import sdfs_pkg::*; #(
  parameter int TAP_COUNT  = TAP_COUNT_DEF,
  parameter int MAX_COLUMN = MAX_COLUMN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] sample
  input  logic                 s_axis_tlast,   // last
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [7:0] depth_index
  output logic                 m_axis_tuser,   // [0] peak_found
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i
);

  logic [SAMPLE_W-1:0] thr_q, off_q;
  logic                push_valid, push_ready;
  item_t               push_item;
  logic                pop_valid, pop_ready;
  item_t               pop_item;
  logic                en;
  logic                v_valid;
  logic [SAMPLE_W-1:0] v_val;
  tag_t                v_tag;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      off_q <= OFF_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PEAK_THRESHOLD: thr_q <= cfg_data_i;
        REG_DEPTH_OFFSET:   off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sdfs_front #(
    .TAP_COUNT  (TAP_COUNT),
    .MAX_COLUMN (MAX_COLUMN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .sample_i     (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .item_o       (push_item)
  );

  sdfs_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_item),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_item)
  );

  sdfs_filter #(
    .TAP_COUNT (TAP_COUNT)
  ) u_filter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .item_valid_i (pop_valid),
    .item_ready_o (pop_ready),
    .item_i       (pop_item),
    .v_valid_o    (v_valid),
    .v_o          (v_val),
    .tag_o        (v_tag)
  );

  sdfs_track u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .v_valid_i     (v_valid),
    .v_i           (v_val),
    .tag_i         (v_tag),
    .thr_i         (thr_q),
    .off_i         (off_q),
    .en_o          (en),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .depth_index_o (m_axis_tdata),
    .peak_found_o  (m_axis_tuser)
  );

endmodule

// File: sv/sdfs_front.sv
module sdfs_front import sdfs_pkg::*; #(
  parameter int TAP_COUNT  = TAP_COUNT_DEF,
  parameter int MAX_COLUMN = MAX_COLUMN_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                last_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output item_t               item_o
);

  localparam int KHALF = (TAP_COUNT - 1) / 2;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             kept;
  logic             accept;

  // Classify the incoming sample against the column position
  assign kept   = cnt_q < CNT_W'(MAX_COLUMN);
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    item_o.sample   = sample_i;
    item_o.push     = kept;
    item_o.first    = (cnt_q == '0);
    item_o.consider = kept && (cnt_q >= CNT_W'(KHALF));
    item_o.last     = last_i;
    item_o.pos      = POS_W'(cnt_q - CNT_W'(KHALF));
    item_o.len_m1   = kept ? cnt_q[POS_W-1:0] : POS_W'(MAX_COLUMN - 1);
  end

  // Drop overlong samples unless they close the column
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && (kept || last_i);

  // Advance the sample count, restart it on the last sample
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (last_i) begin
        cnt_d = '0;
      end else if (kept) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: sv/sdfs_fifo.sv
module sdfs_fifo import sdfs_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  item_t wr_data_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output item_t rd_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_FW = $clog2(DEPTH + 1);

  item_t              mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_FW-1:0]  count_q;
  logic               do_wr, do_rd;

  assign wr_ready_o = count_q != CNT_FW'(DEPTH);
  assign rd_valid_o = count_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CNT_FW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CNT_FW'(1);
      end
    end
  end

endmodule

// File: sv/sdfs_filter.sv
module sdfs_filter import sdfs_pkg::*; #(
  parameter int TAP_COUNT = TAP_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  item_t               item_i,
  output logic                v_valid_o,
  output logic [SAMPLE_W-1:0] v_o,
  output tag_t                tag_o
);

  localparam int KHALF  = (TAP_COUNT - 1) / 2;
  localparam int WIN    = 2 * KHALF + 1;
  localparam int NGRP   = (KHALF + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int LEFT_W = $clog2(KHALF + 1);
  localparam int ZW     = POS_W + 2;

  // Window and edge-flush sequencer
  logic [SAMPLE_W-1:0]      win_q [WIN];
  logic                     flush_q;
  logic [LEFT_W-1:0]        left_q;
  logic signed [ZW-1:0]     z_q;
  logic [POS_W-1:0]         flen_q;
  logic                     pop;
  logic                     w_vld_q;
  tag_t                     w_tag_q, w_tag_d;

  // Pipeline stages
  logic signed [PROD_W-1:0] prod_q [KHALF];
  logic                     p_vld_q;
  tag_t                     p_tag_q;
  logic signed [GRP_W-1:0]  grp_q [NGRP];
  logic signed [GRP_W-1:0]  grp_d [NGRP];
  logic                     s_vld_q;
  tag_t                     s_tag_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     a_vld_q;
  tag_t                     a_tag_q;
  logic [SAMPLE_W-1:0]      v_q, v_d;
  logic                     v_vld_q;
  tag_t                     v_tag_q;
  logic [QUOT_W-1:0]        quot;
  logic [RECIP_W-1:0]       recip_prod;

  assign item_ready_o = en_i && !flush_q;
  assign pop          = item_valid_i && item_ready_o;

  // Tag of the window step taken this cycle
  always_comb begin
    if (flush_q) begin
      w_tag_d.consider = !z_q[ZW-1];
      w_tag_d.fin      = (left_q == LEFT_W'(1));
      w_tag_d.pos      = z_q[POS_W-1:0];
      w_tag_d.len_m1   = flen_q;
    end else begin
      w_tag_d.consider = item_i.consider;
      w_tag_d.fin      = 1'b0;
      w_tag_d.pos      = item_i.pos;
      w_tag_d.len_m1   = item_i.len_m1;
    end
  end

  // Shift the window: fill on the first sample, replicate the edge while flushing
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (flush_q) begin
        for (int j = 0; j < WIN - 1; j++) begin
          win_q[j] <= win_q[j+1];
        end
      end else if (pop && item_i.push) begin
        if (item_i.first) begin
          for (int j = 0; j < WIN; j++) begin
            win_q[j] <= item_i.sample;
          end
        end else begin
          for (int j = 0; j < WIN - 1; j++) begin
            win_q[j] <= win_q[j+1];
          end
          win_q[WIN-1] <= item_i.sample;
        end
      end
    end
  end

  // Run the edge flush after each column's last sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_q <= 1'b0;
      left_q  <= '0;
      w_vld_q <= 1'b0;
    end else if (en_i) begin
      w_vld_q <= flush_q || pop;
      if (flush_q) begin
        left_q <= left_q - LEFT_W'(1);
        if (left_q == LEFT_W'(1)) begin
          flush_q <= 1'b0;
        end
      end else if (pop && item_i.last) begin
        flush_q <= 1'b1;
        left_q  <= LEFT_W'(KHALF);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_tag_q <= w_tag_d;
      if (flush_q) begin
        z_q <= z_q + ZW'(1);
      end else if (pop && item_i.last) begin
        z_q    <= $signed({2'b00, item_i.len_m1}) + ZW'(1) - ZW'(KHALF);
        flen_q <= item_i.len_m1;
      end
    end
  end

  // Weight the antisymmetric differences around the center
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_tag_q <= w_tag_q;
      for (int k = 1; k <= KHALF; k++) begin
        prod_q[k-1] <= PROD_W'(($signed({1'b0, win_q[KHALF+k]}) -
                                $signed({1'b0, win_q[KHALF-k]})) * tap_weight(k));
      end
    end
  end

  // Sum the products in small groups
  always_comb begin
    int idx;
    idx = 0;
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int i = 0; i < GROUP_SIZE; i++) begin
        idx = g * GROUP_SIZE + i;
        if (idx < KHALF) begin
          grp_d[g] = grp_d[g] + GRP_W'(prod_q[idx]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_tag_q <= p_tag_q;
      for (int g = 0; g < NGRP; g++) begin
        grp_q[g] <= grp_d[g];
      end
    end
  end

  // Add the group sums
  always_comb begin
    acc_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      acc_d = acc_d + ACC_W'(grp_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_tag_q <= s_tag_q;
      acc_q   <= acc_d;
    end
  end

  // Scale by 1/163840: drop 15 fraction bits, divide by 5 through a reciprocal
  assign quot       = acc_q[ACC_W-2:Q_SHIFT];
  assign recip_prod = RECIP_W'(quot[DIV_IN_W-1:0]) * RECIP_W'(RECIP);

  always_comb begin
    if (acc_q[ACC_W-1] || (acc_q == '0)) begin
      v_d = '0;
    end else if (quot >= QUOT_W'(SAT_LIMIT)) begin
      v_d = '1;
    end else begin
      v_d = recip_prod[RECIP_SHIFT +: SAMPLE_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_tag_q <= a_tag_q;
      v_q     <= v_d;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
      a_vld_q <= 1'b0;
      v_vld_q <= 1'b0;
    end else if (en_i) begin
      p_vld_q <= w_vld_q;
      s_vld_q <= p_vld_q;
      a_vld_q <= s_vld_q;
      v_vld_q <= a_vld_q;
    end
  end

  assign v_valid_o = v_vld_q;
  assign v_o       = v_q;
  assign tag_o     = v_tag_q;

endmodule

// File: sv/sdfs_track.sv
module sdfs_track import sdfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                v_valid_i,
  input  logic [SAMPLE_W-1:0] v_i,
  input  tag_t                tag_i,
  input  logic [SAMPLE_W-1:0] thr_i,
  input  logic [SAMPLE_W-1:0] off_i,
  output logic                en_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [POS_W-1:0]    depth_index_o,
  output logic                peak_found_o
);

  logic [SAMPLE_W-1:0] peak_q, peak_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic                pvalid_q, pvalid_d;
  logic                done_q, done_d;
  logic                out_vld_q;
  logic [POS_W-1:0]    idx_q, idx_d;
  logic                found_q, found_d;
  logic [POS_W:0]      idx_sum;
  logic                step;

  // Hold the whole back end while a result waits
  assign en_o = !out_vld_q || out_ready_i;
  assign step = en_o && v_valid_i;

  // Track the running maximum until the threshold is passed
  always_comb begin
    peak_d   = peak_q;
    pos_d    = pos_q;
    pvalid_d = pvalid_q;
    done_d   = done_q;
    if (tag_i.consider && !done_q) begin
      if (v_i > peak_q) begin
        peak_d   = v_i;
        pos_d    = tag_i.pos;
        pvalid_d = 1'b1;
      end
      if (v_i > thr_i) begin
        done_d = 1'b1;
      end
    end
  end

  // Form the column result from the updated peak
  assign idx_sum = {1'b0, pos_d} + {1'b0, off_i};

  always_comb begin
    found_d = pvalid_d && (peak_d >= thr_i);
    if (found_d && (idx_sum <= {1'b0, tag_i.len_m1})) begin
      idx_d = idx_sum[POS_W-1:0];
    end else begin
      idx_d = tag_i.len_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q    <= '0;
      pos_q     <= '0;
      pvalid_q  <= 1'b0;
      done_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_o) begin
      out_vld_q <= step && tag_i.fin;
      if (step) begin
        if (tag_i.fin) begin
          peak_q   <= '0;
          pos_q    <= '0;
          pvalid_q <= 1'b0;
          done_q   <= 1'b0;
        end else begin
          peak_q   <= peak_d;
          pos_q    <= pos_d;
          pvalid_q <= pvalid_d;
          done_q   <= done_d;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (en_o && step && tag_i.fin) begin
      idx_q   <= idx_d;
      found_q <= found_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign depth_index_o = idx_q;
  assign peak_found_o  = found_q;

endmodule

// File: sv/sdfs_checker.sv
module sdfs_checker import sdfs_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [7:0]           s_axis_tdata,
  input logic                 s_axis_tlast,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [7:0]           m_axis_tdata,
  input logic                 m_axis_tuser,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input logic [CFG_IDX_W-1:0] cfg_index_i,
  input logic [7:0]           cfg_data_i
);

  // Count columns closed at the input but not yet answered
  logic [7:0] open_q;
  logic       col_in, col_out;

  assign col_in  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign col_out = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (col_in && !col_out) begin
      open_q <= open_q + 8'd1;
    end else if (col_out && !col_in) begin
      open_q <= open_q - 8'd1;
    end
  end

  // A result only answers a column already closed
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (open_q != 8'd0))
    else $error("result without a pending column");

  // A stalled result holds its fields
  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // The configuration port never stalls a write
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind surface_depth_from_scan_column sdfs_checker u_sdfs_checker (.*);
